/* rtl/dwmd_pkg.sv */
`default_nettype none

package dwmd_pkg;

   localparam int BYTE_W    = 8;
   localparam int POS_OUT_W = 16;
   localparam int CFG_W     = 5;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              valid;
      logic              dup;
   } cell_type;

endpackage

`default_nettype wire

/* rtl/dwmd_cell.sv */
`default_nettype none

module dwmd_cell
   import dwmd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic [BYTE_W-1:0] new_byte,
   input  wire cell_type          load,
   output cell_type               fwd
);

   logic [BYTE_W-1:0] data_ff;
   logic              valid_ff;
   logic              dup_ff;

   // mark this byte once a newer copy has entered the row
   assign fwd.data  = data_ff;
   assign fwd.valid = valid_ff;
   assign fwd.dup   = dup_ff | (valid_ff & (data_ff == new_byte));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= load.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= load.data;
         dup_ff  <= load.dup;
      end
   end

endmodule

`default_nettype wire

/* rtl/distinct_window_marker_detect_core.sv */
`default_nettype none

// Marker detector for a byte stream: reports the first byte at which the last
// csr_window_len bytes are all different (0 acts as 1, values above WINDOW_MAX
// act as WINDOW_MAX). One byte is taken per cycle while no result is stalled;
// each accepted item yields one result item in the next cycle, held in an
// output register; a stalled result stops the input until it is taken.
// The recent bytes travel along a row of WINDOW_MAX cells; each cell compares
// its byte with the incoming one in parallel, so the rate is set by that
// compare plus the OR across the row. The position saturates at
// 2^POS_BITS - 1 and is reported clipped to 16 bits; a start_of_stream item
// clears the history before its own byte is taken. csr_window_len may be
// written only while the block is idle.
module distinct_window_marker_detect_core
   import dwmd_pkg::*;
#(
   parameter int WINDOW_MAX = 16,
   parameter int POS_BITS   = 16
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [BYTE_W-1:0]    req_data_byte,
   input  wire logic                 req_start_of_stream,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_marker_found,
   output logic [POS_OUT_W-1:0]      rsp_marker_position,
   output logic                      rsp_marker_seen,
   input  wire logic                 csr_write_enable,
   input  wire logic [CFG_W-1:0]     csr_window_len
);

   localparam logic [POS_BITS-1:0] POS_MAX   = '1;
   localparam int                  WIN_RESET = (WINDOW_MAX < 4) ? WINDOW_MAX : 4;

   logic [WINDOW_MAX-1:0] win_mask_ff;
   logic [WINDOW_MAX-1:0] win_mask_in;
   logic [POS_BITS-1:0]   cnt_ff;
   logic [POS_BITS-1:0]   cnt_in;
   logic                  done_ff;
   logic                  done_in;
   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic [POS_OUT_W-1:0]  rsp_pos_ff;
   logic                  rsp_seen_ff;

   logic                  accept;
   logic                  advance;
   logic                  sat;
   logic [POS_BITS-1:0]   cnt_base;
   logic [POS_BITS-1:0]   pos;
   logic [POS_OUT_W-1:0]  pos_out;
   logic                  done_base;
   logic                  clash;
   logic                  found;

   cell_type              load [WINDOW_MAX];
   cell_type              fwd  [WINDOW_MAX];

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   assign cnt_base  = req_start_of_stream ? '0 : cnt_ff;
   assign done_base = req_start_of_stream ? 1'b0 : done_ff;
   assign sat       = (cnt_base == POS_MAX);
   assign pos       = sat ? POS_MAX : cnt_base + 1'b1;
   assign advance   = accept & ~sat;

   for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign load[k] = '{data: req_data_byte, valid: 1'b1, dup: 1'b0};
      end else begin : g_body
         assign load[k] = req_start_of_stream ? cell_type'('0) : fwd[k-1];
      end

      dwmd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .new_byte (req_data_byte),
         .load     (load[k]),
         .fwd      (fwd[k])
      );

      assign win_mask_in[k] = (k == 0) || (k < int'(csr_window_len));
   end

   always_comb begin
      clash = 1'b0;
      for (int k = 0; k < WINDOW_MAX; k++) begin
         clash = clash | (win_mask_ff[k] & (~load[k].valid | load[k].dup));
      end
   end

   assign found   = advance & ~done_base & ~clash;
   assign done_in = done_base | found;
   assign cnt_in  = pos;

   if (POS_BITS > POS_OUT_W) begin : g_clip
      assign pos_out = (|pos[POS_BITS-1:POS_OUT_W]) ? '1 : pos[POS_OUT_W-1:0];
   end else begin : g_ext
      assign pos_out = POS_OUT_W'(pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW_MAX; k++) begin
            win_mask_ff[k] <= (k < WIN_RESET);
         end
      end else if (csr_write_enable) begin
         win_mask_ff <= win_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            cnt_ff  <= cnt_in;
            done_ff <= done_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_found_ff <= found;
         rsp_pos_ff   <= pos_out;
         rsp_seen_ff  <= done_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_marker_found    = rsp_found_ff;
   assign rsp_marker_position = rsp_pos_ff;
   assign rsp_marker_seen     = rsp_seen_ff;

`ifndef SYNTHESIS
   a_found_implies_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_seen_ff)
      else $error("marker found without marker seen");

   a_count_advances: assert property (@(posedge clock) disable iff (reset)
      accept && !req_start_of_stream && cnt_ff != POS_MAX |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("byte count did not advance");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      accept && !sat |=> fwd[0].valid)
      else $error("head cell empty after a byte");

   a_window_nonzero: assert property (@(posedge clock) disable iff (reset)
      win_mask_ff[0])
      else $error("window mask empty");

   a_no_find_when_done: assert property (@(posedge clock) disable iff (reset)
      accept && !req_start_of_stream && done_ff |=> !rsp_found_ff)
      else $error("second marker reported");
`endif

endmodule

`default_nettype wire

/* dv/distinct_window_marker_detect_core_tb.sv */
`default_nettype none

module distinct_window_marker_detect_core_tb
   import dwmd_pkg::*;
();

   localparam int TB_WINDOW_MAX = 16;
   localparam int TB_POS_BITS = 16;
   localparam logic [TB_POS_BITS-1:0] POS_SAT = '1;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 3;

   typedef struct packed {
      logic                 found;
      logic [POS_OUT_W-1:0] position;
      logic                 seen;
   } report_type;

   typedef struct packed {
      bit              is_cfg;
      logic [CFG_W-1:0] cfg;
      logic [BYTE_W-1:0] data;
      logic            sos;
      bit              typed;
      report_type      want;
   } step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [BYTE_W-1:0]    req_data_byte = '0;
   logic                 req_start_of_stream = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_marker_found;
   logic [POS_OUT_W-1:0] rsp_marker_position;
   logic                 rsp_marker_seen;
   logic                 csr_write_enable = 1'b0;
   logic [CFG_W-1:0]     csr_window_len = '0;

   logic [TB_POS_BITS-1:0] last_pos [256];
   bit                     seen_tab [256] = '{default: 1'b0};
   logic [TB_POS_BITS-1:0] byte_count = '0;
   logic [TB_POS_BITS-1:0] repeat_limit = '0;
   bit                     marker_done = 1'b0;
   logic [CFG_W-1:0]       window_reg = 5'd4;

   report_type pending_reports [$];
   report_type oldest;
   int      errors = 0;
   int      idle_cycles = 0;
   bit      steady = 1'b0;

   step_type directed_steps [24] = '{
      '{1'b0, 5'd0,  8'h00, 1'b0, 1'b1, '{1'b0, 16'd1, 1'b0}},
      '{1'b0, 5'd0,  8'hFF, 1'b0, 1'b1, '{1'b0, 16'd2, 1'b0}},
      '{1'b0, 5'd0,  8'h00, 1'b0, 1'b1, '{1'b0, 16'd3, 1'b0}},
      '{1'b0, 5'd0,  8'h80, 1'b0, 1'b1, '{1'b0, 16'd4, 1'b0}},
      '{1'b0, 5'd0,  8'h01, 1'b0, 1'b1, '{1'b1, 16'd5, 1'b1}},
      '{1'b0, 5'd0,  8'h02, 1'b0, 1'b1, '{1'b0, 16'd6, 1'b1}},
      '{1'b0, 5'd0,  8'hAA, 1'b1, 1'b1, '{1'b0, 16'd1, 1'b0}},
      '{1'b0, 5'd0,  8'h55, 1'b0, 1'b1, '{1'b0, 16'd2, 1'b0}},
      '{1'b0, 5'd0,  8'hAA, 1'b0, 1'b1, '{1'b0, 16'd3, 1'b0}},
      '{1'b0, 5'd0,  8'h55, 1'b0, 1'b1, '{1'b0, 16'd4, 1'b0}},
      '{1'b0, 5'd0,  8'h7F, 1'b0, 1'b1, '{1'b0, 16'd5, 1'b0}},
      '{1'b0, 5'd0,  8'hFE, 1'b0, 1'b1, '{1'b1, 16'd6, 1'b1}},
      '{1'b1, 5'd0,  8'h00, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  8'h33, 1'b1, 1'b1, '{1'b1, 16'd1, 1'b1}},
      '{1'b0, 5'd0,  8'h33, 1'b0, 1'b1, '{1'b0, 16'd2, 1'b1}},
      '{1'b1, 5'd31, 8'h00, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  8'h10, 1'b1, 1'b0, '0},
      '{1'b0, 5'd0,  8'h20, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  8'h40, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  8'h10, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  8'h08, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  8'h04, 1'b0, 1'b0, '0},
      '{1'b1, 5'd1,  8'h00, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  8'hC3, 1'b1, 1'b1, '{1'b1, 16'd1, 1'b1}}
   };

   distinct_window_marker_detect_core #(
      .WINDOW_MAX(TB_WINDOW_MAX),
      .POS_BITS  (TB_POS_BITS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_start_of_stream(req_start_of_stream),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_marker_found   (rsp_marker_found),
      .rsp_marker_position(rsp_marker_position),
      .rsp_marker_seen    (rsp_marker_seen),
      .csr_write_enable   (csr_write_enable),
      .csr_window_len     (csr_window_len)
   );

   always #1 clock = ~clock;

   function automatic report_type predict_marker(logic [BYTE_W-1:0] b, logic sos);
      int unsigned w;
      report_type r;
      w = 32'(window_reg);
      if (w < 1) w = 1;
      if (w > TB_WINDOW_MAX) w = TB_WINDOW_MAX;
      if (sos) begin
         seen_tab = '{default: 1'b0};
         byte_count = '0;
         repeat_limit = '0;
         marker_done = 1'b0;
      end
      r.found = 1'b0;
      if (byte_count == POS_SAT) begin
         r.position = POS_SAT;
      end else begin
         byte_count = byte_count + 1'b1;
         r.position = byte_count;
         if (seen_tab[b] && last_pos[b] > repeat_limit) repeat_limit = last_pos[b];
         last_pos[b] = byte_count;
         seen_tab[b] = 1'b1;
         if (!marker_done && (byte_count - repeat_limit) >= w) begin
            r.found = 1'b1;
            marker_done = 1'b1;
         end
      end
      r.seen = marker_done;
      return r;
   endfunction

   function automatic void note_mismatch(string field, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endfunction

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 10);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual found %0d pos %0d seen %0d",
                     $time, rsp_marker_found, rsp_marker_position, rsp_marker_seen);
         end else begin
            oldest = pending_reports.pop_front();
            if (rsp_marker_found !== oldest.found)
               note_mismatch("marker_found", 32'(oldest.found), 32'(rsp_marker_found));
            if (rsp_marker_position !== oldest.position)
               note_mismatch("marker_position", 32'(oldest.position),
                             32'(rsp_marker_position));
            if (rsp_marker_seen !== oldest.seen)
               note_mismatch("marker_seen", 32'(oldest.seen), 32'(rsp_marker_seen));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic sos, input bit typed,
                            input report_type want);
      report_type predicted;
      int gap;
      gap = (!steady && $urandom_range(99) < 10) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_start_of_stream <= sos;
      do @(posedge clock); while (!req_ready);
      predicted = predict_marker(b, sos);
      pending_reports.push_back(typed ? want : predicted);
   endtask

   task automatic drain_reports();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [CFG_W-1:0] w);
      drain_reports();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_window_len <= w;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      window_reg = w;
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] w, input int quota, input bit pause_mid);
      int taken;
      int run_len;
      int span;
      int eff;
      bit paused;
      logic [BYTE_W-1:0] base;
      logic [BYTE_W-1:0] b;
      report_type no_report;
      no_report = '0;
      eff = (w == 0) ? 1 : ((w > TB_WINDOW_MAX) ? TB_WINDOW_MAX : int'(w));
      write_window(w);
      taken = 0;
      paused = 1'b0;
      while (taken < quota) begin
         if (pause_mid && !paused && taken >= quota / 2) begin
            drain_reports();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 80) begin
            // well-formed stream over a narrow alphabet so repeats land inside the window
            run_len = $urandom_range(1, 2 * eff + 8);
            span = $urandom_range(eff / 2 + 1, eff + 3);
            base = BYTE_W'($urandom);
            for (int i = 0; i < run_len; i++) begin
               b = ($urandom_range(7) == 0) ? BYTE_W'($urandom)
                                           : base + BYTE_W'($urandom_range(span - 1));
               send_byte(b, i == 0, 1'b0, no_report);
            end
         end else begin
            run_len = $urandom_range(1, 10);
            for (int i = 0; i < run_len; i++)
               send_byte(BYTE_W'($urandom), $urandom_range(15) == 0, 1'b0, no_report);
         end
         taken += run_len;
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_cfg)
            write_window(directed_steps[i].cfg);
         else
            send_byte(directed_steps[i].data, directed_steps[i].sos,
                      directed_steps[i].typed, directed_steps[i].want);
      end

      run_phase(5'd1, 60, 1'b0);
      run_phase(5'd16, 60, 1'b0);
      run_phase(5'd2, 60, 1'b1);
      run_phase(5'd17, 60, 1'b0);
      steady = 1'b1;
      run_phase(5'd14, 60, 1'b0);
      steady = 1'b0;
      run_phase(5'd0, 50, 1'b0);
      run_phase(5'd4, 60, 1'b0);
      run_phase(5'd15, 60, 1'b0);
      run_phase(5'd3, 60, 1'b0);
      run_phase(CFG_W'($urandom_range(0, 31)), 60, 1'b0);

      drain_reports();
      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
